@@ rtl/core/ippc_pkg.sv @@
// Shared types, constants and window helpers for the isolated plus pattern counter.
// No dependencies; every file of the block refers to this package by scoped names.
package ippc_pkg;

  localparam int CFG_W       = 11;
  localparam int OUT_W       = 20;
  localparam int MAX_COLS    = 1024;
  localparam int MAX_ROWS    = 1024;
  localparam int COUNT_BITS  = 20;
  localparam int QUEUE_DEPTH = 2;
  localparam int WIN_SIDE    = 5;
  localparam int WIN_BITS    = WIN_SIDE * WIN_SIDE;
  localparam int HIST_BITS   = WIN_SIDE - 1;

  localparam logic [CFG_W-1:0]    GRID_RESET = CFG_W'(1024);
  localparam logic [WIN_BITS-1:0] WIN_COL0   = WIN_BITS'(25'h0108421);

  typedef enum logic [0:0] {
    REG_GRID_ROWS = 1'b0,
    REG_GRID_COLS = 1'b1
  } reg_idx_t;

  // Position classes of one cell, worked out by the front end.
  typedef struct packed {
    logic r_ge2;
    logic r_ge3;
    logic r_ge4;
    logic c_ge2;
    logic c_ge3;
    logic c_ge4;
    logic last_row;
    logic last_col;
  } flags_t;

  // Window cell rb rows and cb columns back from the newest cell; zero outside.
  function automatic logic win_bit(input logic [WIN_BITS-1:0] win, input int rb, input int cb);
    logic b;
    b = 1'b0;
    if (rb >= 0 && rb < WIN_SIDE && cb >= 0 && cb < WIN_SIDE) begin
      b = win[rb * WIN_SIDE + cb];
    end
    return b;
  endfunction

  // Plus test around the center (ci, cj). The far cells down and right fall
  // outside the window where they are not to be checked, so only the far
  // cells up and left need an enable.
  function automatic logic plus_hit(input logic [WIN_BITS-1:0] win, input int ci, input int cj,
                                    input logic dn, input logic lf);
    logic arms;
    logic diag;
    logic far;
    arms = win_bit(win, ci, cj) & win_bit(win, ci + 1, cj) & win_bit(win, ci - 1, cj) &
           win_bit(win, ci, cj + 1) & win_bit(win, ci, cj - 1);
    diag = win_bit(win, ci + 1, cj + 1) | win_bit(win, ci + 1, cj - 1) |
           win_bit(win, ci - 1, cj + 1) | win_bit(win, ci - 1, cj - 1);
    far  = (dn & win_bit(win, ci + 2, cj)) | win_bit(win, ci - 2, cj) |
           (lf & win_bit(win, ci, cj + 2)) | win_bit(win, ci, cj - 2);
    return arms & ~diag & ~far;
  endfunction

endpackage

@@ rtl/core/ippc_front.sv @@
// Front end: accepts cells, tracks the raster position and classifies each cell.
// Depends on ippc_pkg (flags_t).
module ippc_front #(
  parameter int MAX_COLS = ippc_pkg::MAX_COLS,
  parameter int MAX_ROWS = ippc_pkg::MAX_ROWS,
  localparam int CW  = $clog2(MAX_COLS),
  localparam int RW  = $clog2(MAX_ROWS),
  localparam int NCW = $clog2(MAX_COLS + 1),
  localparam int NRW = $clog2(MAX_ROWS + 1)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       restart,
  input  logic [ippc_pkg::CFG_W-1:0] grid_rows,
  input  logic [ippc_pkg::CFG_W-1:0] grid_cols,
  input  logic                       in_valid,
  input  logic                       cell_is_one,
  input  logic                       q_full,
  output logic                       in_ready,
  output logic                       push,
  output logic                       push_cell,
  output logic [CW-1:0]              push_col,
  output ippc_pkg::flags_t           push_flags
);

  logic [RW-1:0]  row_pos;
  logic [CW-1:0]  col_pos;
  logic [NRW-1:0] nr_eff;
  logic [NCW-1:0] nc_eff;
  logic           accept;

  // Clamp sizes to 1..max.
  always_comb begin
    if (grid_rows == '0) begin
      nr_eff = NRW'(1);
    end else if (32'(grid_rows) > 32'(MAX_ROWS)) begin
      nr_eff = NRW'(MAX_ROWS);
    end else begin
      nr_eff = NRW'(grid_rows);
    end
    if (grid_cols == '0) begin
      nc_eff = NCW'(1);
    end else if (32'(grid_cols) > 32'(MAX_COLS)) begin
      nc_eff = NCW'(MAX_COLS);
    end else begin
      nc_eff = NCW'(grid_cols);
    end
  end

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign push     = accept;
  assign push_cell = cell_is_one;
  assign push_col  = col_pos;

  always_comb begin
    push_flags.r_ge2    = 32'(row_pos) >= 32'd2;
    push_flags.r_ge3    = 32'(row_pos) >= 32'd3;
    push_flags.r_ge4    = 32'(row_pos) >= 32'd4;
    push_flags.c_ge2    = 32'(col_pos) >= 32'd2;
    push_flags.c_ge3    = 32'(col_pos) >= 32'd3;
    push_flags.c_ge4    = 32'(col_pos) >= 32'd4;
    push_flags.last_row = (32'(row_pos) + 32'd1) >= 32'(nr_eff);
    push_flags.last_col = (32'(col_pos) + 32'd1) >= 32'(nc_eff);
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      row_pos <= '0;
      col_pos <= '0;
    end else if (accept) begin
      if (push_flags.last_col) begin
        col_pos <= '0;
        if (push_flags.last_row) begin
          row_pos <= '0;
        end else begin
          row_pos <= row_pos + RW'(1);
        end
      end else begin
        col_pos <= col_pos + CW'(1);
      end
    end
  end

endmodule

@@ rtl/core/ippc_queue.sv @@
// Short queue between front end and back end, so each side stalls on its own.
// Depends on ippc_pkg (QUEUE_DEPTH).
module ippc_queue #(
  parameter int WIDTH = 1,
  localparam int PW = $clog2(ippc_pkg::QUEUE_DEPTH),
  localparam int NW = $clog2(ippc_pkg::QUEUE_DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic             full,
  output logic             not_empty,
  output logic [WIDTH-1:0] head
);

  logic [WIDTH-1:0] slots [ippc_pkg::QUEUE_DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [NW-1:0]    fill;
  logic             do_pop;

  assign full      = fill == NW'(ippc_pkg::QUEUE_DEPTH);
  assign not_empty = fill != '0;
  assign head      = slots[rd_ptr];
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      if (push && !do_pop) begin
        fill <= fill + NW'(1);
      end else if (do_pop && !push) begin
        fill <= fill - NW'(1);
      end
    end
  end

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    !(push && full))
    else $error("queue pushed while full");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    32'(fill) <= ippc_pkg::QUEUE_DEPTH)
    else $error("queue fill count out of range");

endmodule

@@ rtl/core/ippc_back.sv @@
// Back end: row store, 5x5 window, plus detection, saturating count and result register.
// Depends on ippc_pkg (flags_t, plus_hit, window constants).
module ippc_back #(
  parameter int MAX_COLS   = ippc_pkg::MAX_COLS,
  parameter int COUNT_BITS = ippc_pkg::COUNT_BITS,
  localparam int CW = $clog2(MAX_COLS)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       restart,
  input  logic                       q_valid,
  input  logic                       q_cell,
  input  logic [CW-1:0]              q_col,
  input  ippc_pkg::flags_t           q_flags,
  output logic                       q_pop,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [ippc_pkg::OUT_W-1:0] plus_count
);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  logic [ippc_pkg::HIST_BITS-1:0] row_store [MAX_COLS];

  logic                             b_valid;
  logic                             b_cell;
  logic [CW-1:0]                    b_col;
  ippc_pkg::flags_t                 b_flags;
  logic [ippc_pkg::HIST_BITS-1:0]   b_hist;
  logic [ippc_pkg::WIN_BITS-1:0]    window_bits;
  logic [ippc_pkg::WIN_BITS-1:0]    window_next;
  logic [COUNT_BITS-1:0]            match_total;
  logic [COUNT_BITS-1:0]            match_next;
  logic [COUNT_BITS:0]              match_sum;
  logic [ippc_pkg::WIN_SIDE-1:0]    vec;
  logic [ippc_pkg::WIN_BITS-1:0]    spread;
  logic [3:0]                       hits;
  logic [2:0]                       hit_count;
  logic                             frame_end;
  logic                             fire;
  logic [31:0]                      count_wide;

  assign frame_end = b_flags.last_row && b_flags.last_col;
  assign fire      = b_valid && (!frame_end || !out_valid || out_ready);
  assign q_pop     = !b_valid || fire;

  // Row store read is registered: it lands in b_hist as the item enters the
  // stage. Same-column read and write in one cycle only happens with a
  // one-column grid, which never counts anything.
  always_ff @(posedge clk) begin
    if (q_valid && q_pop) begin
      b_hist <= row_store[q_col];
    end
    if (fire) begin
      row_store[b_col] <= vec[ippc_pkg::HIST_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (q_valid && q_pop) begin
      b_cell  <= q_cell;
      b_col   <= q_col;
      b_flags <= q_flags;
    end
  end

  always_comb begin
    vec    = {b_hist, b_cell};
    spread = '0;
    for (int k = 0; k < ippc_pkg::WIN_SIDE; k++) begin
      spread[k * ippc_pkg::WIN_SIDE] = vec[k];
    end
    window_next = ((window_bits << 1) & ~ippc_pkg::WIN_COL0) | spread;
  end

  // Centers two back, plus the ones on the bottom row and right column.
  always_comb begin
    hits[0] = b_flags.r_ge3 & b_flags.c_ge3 &
              ippc_pkg::plus_hit(window_next, 2, 2, b_flags.r_ge4, b_flags.c_ge4);
    hits[1] = b_flags.last_col & b_flags.r_ge3 & b_flags.c_ge2 &
              ippc_pkg::plus_hit(window_next, 2, 1, b_flags.r_ge4, b_flags.c_ge3);
    hits[2] = b_flags.last_row & b_flags.r_ge2 & b_flags.c_ge3 &
              ippc_pkg::plus_hit(window_next, 1, 2, b_flags.r_ge3, b_flags.c_ge4);
    hits[3] = b_flags.last_row & b_flags.last_col & b_flags.r_ge2 & b_flags.c_ge2 &
              ippc_pkg::plus_hit(window_next, 1, 1, b_flags.r_ge3, b_flags.c_ge3);
    hit_count = 3'(hits[0]) + 3'(hits[1]) + 3'(hits[2]) + 3'(hits[3]);
    match_sum = {1'b0, match_total} + (COUNT_BITS + 1)'(hit_count);
    match_next = match_sum[COUNT_BITS] ? COUNT_MAX : match_sum[COUNT_BITS-1:0];
    count_wide = 32'(match_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_bits <= '0;
    end else if (fire) begin
      window_bits <= window_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid     <= 1'b0;
      match_total <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (q_pop) begin
        b_valid <= q_valid;
      end
      if (restart) begin
        match_total <= '0;
      end else if (fire) begin
        match_total <= frame_end ? '0 : match_next;
      end
      if (fire && frame_end) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && frame_end) begin
      plus_count <= count_wide[ippc_pkg::OUT_W-1:0];
    end
  end

  a_result_follows_frame_end: assert property (@(posedge clk) disable iff (rst)
    fire && frame_end |=> out_valid)
    else $error("frame end did not load a result");

  a_count_cleared_after_frame: assert property (@(posedge clk) disable iff (rst)
    fire && frame_end |=> match_total == '0)
    else $error("count not cleared after frame end");

  a_stall_only_on_full_output: assert property (@(posedge clk) disable iff (rst)
    b_valid && !fire |-> out_valid && !out_ready)
    else $error("back end stalled without a blocked result");

endmodule

@@ rtl/core/isolated_plus_pattern_counter.sv @@
// Top level of the isolated plus pattern counter: configuration port and the
// front end, queue and back end. Depends on ippc_pkg, ippc_front, ippc_queue, ippc_back.
//
// The block takes a binary image one cell per clock in raster order and, with the
// last cell of each frame, returns one item: the saturating number of isolated
// plus shapes found. It sustains one cell per cycle while the queue is not full; that
// rate is set by the row store, which is read once and written once per cell (one read
// port, one write port), and by the window shift that goes with it. When the output
// side is ready, the last cell moves from the queue into the detect stage, then the
// result register loads and out_valid rises. The front end keeps accepting cells
// while a result waits; the two-entry queue and the result register absorb a stall
// on the output side until the queue fills. The row store is not cleared after
// reset, so there is no clearing pass: its unwritten entries only ever feed window
// cells outside any decision. Writing either size register restarts the frame
// (position and count go to zero); write only while the block is idle. A size of
// zero acts as one, and a size above the maximum acts as the maximum.
module isolated_plus_pattern_counter #(
  parameter int MAX_COLS   = ippc_pkg::MAX_COLS,
  parameter int MAX_ROWS   = ippc_pkg::MAX_ROWS,
  parameter int COUNT_BITS = ippc_pkg::COUNT_BITS
) (
  input  logic                       clk,
  input  logic                       rst,
  // configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [2:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  // cell stream
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       cell_is_one,
  // results
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [ippc_pkg::OUT_W-1:0] plus_count
);

  localparam int CW = $clog2(MAX_COLS);
  localparam int FW = $bits(ippc_pkg::flags_t);
  localparam int QW = FW + CW + 1;

  logic [ippc_pkg::CFG_W-1:0] grid_rows;
  logic [ippc_pkg::CFG_W-1:0] grid_cols;
  ippc_pkg::reg_idx_t         reg_idx;
  logic                       cfg_write;

  logic                       push;
  logic                       push_cell;
  logic [CW-1:0]              push_col;
  ippc_pkg::flags_t           push_flags;
  logic                       q_full;
  logic                       q_valid;
  logic                       q_pop;
  logic [QW-1:0]              q_head;
  logic                       q_cell;
  logic [CW-1:0]              q_col;
  ippc_pkg::flags_t           q_flags;

  // Registers sit at byte addresses 0 and 4; the access cycle commits a write.
  assign pready    = 1'b1;
  assign reg_idx   = ippc_pkg::reg_idx_t'(paddr[2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_rows <= ippc_pkg::GRID_RESET;
      grid_cols <= ippc_pkg::GRID_RESET;
    end else if (cfg_write) begin
      unique case (reg_idx)
        ippc_pkg::REG_GRID_ROWS: grid_rows <= pwdata[ippc_pkg::CFG_W-1:0];
        ippc_pkg::REG_GRID_COLS: grid_cols <= pwdata[ippc_pkg::CFG_W-1:0];
        default:                 grid_rows <= grid_rows;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      ippc_pkg::REG_GRID_ROWS: prdata = 32'(grid_rows);
      ippc_pkg::REG_GRID_COLS: prdata = 32'(grid_cols);
      default:                 prdata = '0;
    endcase
  end

  // Front end: position tracking and classification of each cell.
  ippc_front #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .restart     (cfg_write),
    .grid_rows   (grid_rows),
    .grid_cols   (grid_cols),
    .in_valid    (in_valid),
    .cell_is_one (cell_is_one),
    .q_full      (q_full),
    .in_ready    (in_ready),
    .push        (push),
    .push_cell   (push_cell),
    .push_col    (push_col),
    .push_flags  (push_flags)
  );

  // Hold classified cells until the back end takes them.
  ippc_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({push_flags, push_col, push_cell}),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_valid),
    .head      (q_head)
  );

  assign q_cell  = q_head[0];
  assign q_col   = q_head[CW:1];
  assign q_flags = ippc_pkg::flags_t'(q_head[QW-1:CW+1]);

  // Back end: row store, window, detection, count and result register.
  ippc_back #(
    .MAX_COLS   (MAX_COLS),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .restart    (cfg_write),
    .q_valid    (q_valid),
    .q_cell     (q_cell),
    .q_col      (q_col),
    .q_flags    (q_flags),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .plus_count (plus_count)
  );

endmodule

@@ tb/ippc_frame_checker.sv @@
// Frame checker for the isolated plus pattern counter: follows size register
// writes and the cell stream, predicts each frame count and compares results.
// Depends on ippc_pkg for sizes, widths and register indexes.
module ippc_frame_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [2:0]                 paddr,
  input  logic [31:0]                pwdata,
  input  logic                       pready,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic                       cell_is_one,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic [ippc_pkg::OUT_W-1:0] plus_count,
  output int unsigned                fail_count,
  output int unsigned                pending,
  output int unsigned                cells_taken,
  output int unsigned                frames_checked,
  output int unsigned                peak_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          SIDE      = 5;
  localparam logic [24:0] FIRST_COL = 25'h0108421;

  logic [ippc_pkg::CFG_W-1:0]      rows_reg;
  logic [ippc_pkg::CFG_W-1:0]      cols_reg;
  logic [3:0]                      hist [ippc_pkg::MAX_COLS];
  logic [24:0]                     win;
  int                              row_at;
  int                              col_at;
  logic [ippc_pkg::COUNT_BITS-1:0] tally;
  logic [ippc_pkg::OUT_W-1:0]      frame_counts [$];

  task automatic report_bad(input string what);
    fail_count++;
    $display("%0t ns: mismatch: %s", $time, what);
  endtask

  function automatic int fit_size(input logic [ippc_pkg::CFG_W-1:0] v, input int top);
    if (v == '0) return 1;
    if (int'(v) > top) return top;
    return int'(v);
  endfunction

  // Window cell rb rows and cb columns back from the newest cell.
  function automatic bit win_tap(input int rb, input int cb);
    if (rb < 0 || rb >= SIDE || cb < 0 || cb >= SIDE) return 1'b0;
    return win[rb * SIDE + cb];
  endfunction

  // Plus with its center ci/cj back in the window, at grid position i/j.
  function automatic bit cross_at(input int ci, input int cj, input int i, input int j,
                                  input int nr, input int nc);
    if (i < 1 || i + 2 > nr || j < 1 || j + 2 > nc) return 1'b0;
    if (!win_tap(ci, cj) || !win_tap(ci + 1, cj) || !win_tap(ci - 1, cj) ||
        !win_tap(ci, cj + 1) || !win_tap(ci, cj - 1)) return 1'b0;
    if (win_tap(ci + 1, cj + 1) || win_tap(ci + 1, cj - 1) ||
        win_tap(ci - 1, cj + 1) || win_tap(ci - 1, cj - 1)) return 1'b0;
    // far cells count only where they lie inside the grid
    if (i >= 2 && win_tap(ci + 2, cj)) return 1'b0;
    if (i + 3 <= nr && win_tap(ci - 2, cj)) return 1'b0;
    if (j >= 2 && win_tap(ci, cj + 2)) return 1'b0;
    if (j + 3 <= nc && win_tap(ci, cj - 2)) return 1'b0;
    return 1'b1;
  endfunction

  task automatic bump_tally();
    if (tally != '1) tally++;
  endtask

  task automatic take_cell(input logic v);
    int          nr;
    int          nc;
    int          r;
    int          c;
    int          k;
    logic [4:0]  column;
    logic [24:0] spread;
    nr = fit_size(rows_reg, ippc_pkg::MAX_ROWS);
    nc = fit_size(cols_reg, ippc_pkg::MAX_COLS);
    r = row_at;
    c = col_at;
    column = {hist[c % ippc_pkg::MAX_COLS], v};
    spread = '0;
    for (k = 0; k < SIDE; k++) spread[k * SIDE] = column[k];
    hist[c % ippc_pkg::MAX_COLS] = column[3:0];
    win = ((win << 1) & ~FIRST_COL) | spread;

    if (r >= 2 && c >= 2 && cross_at(2, 2, r - 2, c - 2, nr, nc)) bump_tally();
    if (c + 1 == nc && r >= 2 && c >= 1 && cross_at(2, 1, r - 2, c - 1, nr, nc))
      bump_tally();
    if (r + 1 == nr && r >= 1 && c >= 2 && cross_at(1, 2, r - 1, c - 2, nr, nc))
      bump_tally();
    if (r + 1 == nr && c + 1 == nc && r >= 1 && c >= 1 &&
        cross_at(1, 1, r - 1, c - 1, nr, nc)) bump_tally();

    if (c + 1 >= nc) begin
      col_at = 0;
      if (r + 1 >= nr) begin
        frame_counts.push_back(tally[ippc_pkg::OUT_W-1:0]);
        row_at = 0;
        tally = '0;
      end else begin
        row_at = r + 1;
      end
    end else begin
      col_at = c + 1;
    end
    cells_taken++;
  endtask

  task automatic apply_write();
    bit restart;
    restart = 1'b0;
    if (paddr == {ippc_pkg::REG_GRID_ROWS, 2'b00}) begin
      rows_reg = pwdata[ippc_pkg::CFG_W-1:0];
      restart = 1'b1;
    end else if (paddr == {ippc_pkg::REG_GRID_COLS, 2'b00}) begin
      cols_reg = pwdata[ippc_pkg::CFG_W-1:0];
      restart = 1'b1;
    end
    // a size write starts a new frame; the row store keeps its contents
    if (restart) begin
      row_at = 0;
      col_at = 0;
      tally = '0;
    end
  endtask

  task automatic check_count();
    logic [ippc_pkg::OUT_W-1:0] want;
    if (frame_counts.size() == 0) begin
      report_bad($sformatf("plus_count %0d with no frame finished", plus_count));
    end else begin
      want = frame_counts.pop_front();
      if (plus_count !== want)
        report_bad($sformatf("plus_count %0d, predicted %0d", plus_count, want));
      frames_checked++;
      if (int'(want) > peak_count) peak_count = 32'(want);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      foreach (hist[k]) hist[k] = '0;
      win = '0;
      row_at = 0;
      col_at = 0;
      tally = '0;
      rows_reg = ippc_pkg::GRID_RESET;
      cols_reg = ippc_pkg::GRID_RESET;
      frame_counts.delete();
    end else begin
      if (out_valid && out_ready) check_count();
      if (psel && penable && pwrite && pready) apply_write();
      if (in_valid && in_ready) take_cell(cell_is_one);
    end
    pending = frame_counts.size();
  end

endmodule

@@ tb/tb_top.sv @@
// Top of the isolated plus pattern counter bench: clock, reset, size writes,
// cell stimulus, output back-pressure and the verdict.
// Depends on ippc_pkg, isolated_plus_pattern_counter and ippc_frame_checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Slowest legal run stays far below this: roughly 1800 cells, a 64% stalled
  // receiver, one long hold-off and a settle pass around every size write.
  localparam int CLOCK_LIMIT = 300000;
  localparam int SETTLE      = 8;
  localparam int PRESS_HOLD  = 300;

  logic                       clk         = 1'b0;
  logic                       rst         = 1'b1;
  logic                       psel        = 1'b0;
  logic                       penable     = 1'b0;
  logic                       pwrite      = 1'b0;
  logic [2:0]                 paddr       = '0;
  logic [31:0]                pwdata      = '0;
  logic [31:0]                prdata;
  logic                       pready;
  logic                       in_valid    = 1'b0;
  logic                       in_ready;
  logic                       cell_is_one = 1'b0;
  logic                       out_valid;
  logic                       out_ready   = 1'b0;
  logic [ippc_pkg::OUT_W-1:0] plus_count;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned cells_taken;
  int unsigned frames_checked;
  int unsigned peak_count;

  // Idle rates in percent, the receiver hold-off and the frame being built.
  int          tx_idle_pct   = 0;
  int          rx_idle_pct   = 0;
  int          stall_left    = 0;
  int          frame_rows    = 1;
  int          frame_cols    = 1;
  int          size_settings = 0;
  int unsigned cycle_count   = 0;
  bit [1023:0] pic [1024];

  isolated_plus_pattern_counter DUT (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .cell_is_one (cell_is_one),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .plus_count  (plus_count)
  );

  ippc_frame_checker plus_chk (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .pready         (pready),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .cell_is_one    (cell_is_one),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .plus_count     (plus_count),
    .fail_count     (fail_count),
    .pending        (pending),
    .cells_taken    (cells_taken),
    .frames_checked (frames_checked),
    .peak_count     (peak_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Give up on a hang: a lost result or a stuck handshake ends here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CLOCK_LIMIT) begin
      $display("timeout after %0d cycles with %0d frame counts outstanding",
               cycle_count, pending);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Receiver: drop ready at the current idle rate; during a hold-off keep it
  // low for the whole stretch so the cell queue fills and the block pushes
  // back on the cell stream.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Effective frame span for a size register value: zero acts as one, and
  // anything past the maximum acts as the maximum.
  function automatic int span_of(input logic [ippc_pkg::CFG_W-1:0] v, input int top);
    if (v == '0) return 1;
    if (int'(v) > top) return top;
    return int'(v);
  endfunction

  // Offer one cell; hold valid and data until the block takes it. Called
  // right after a rising edge, returns on the edge that accepts the item.
  task automatic push_cell(input logic v);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    cell_is_one <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Stream the first n cells of the picture in raster order. Valid stays
  // high across frame boundaries unless the sender chooses to idle.
  task automatic send_frame(input int n);
    int r;
    int c;
    for (int k = 0; k < n; k++) begin
      r = k / frame_cols;
      c = k % frame_cols;
      push_cell(pic[r][c]);
    end
  endtask

  // Drop valid, wait for every predicted count to come out, then let the
  // pipeline settle so a half-built frame leaves nothing in flight.
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Setup cycle, access cycle, then an idle wait with psel low so that back-to-back
  // writes never assign psel twice in one step.
  task automatic write_reg(input ippc_pkg::reg_idx_t which,
                           input logic [ippc_pkg::CFG_W-1:0] size);
    logic [31:0] word;
    // junk in the unused upper bits must be ignored
    word = {($urandom_range(4) == 0) ? 21'($urandom()) : 21'd0, size};
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {which, 2'b00};
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_grid(input logic [ippc_pkg::CFG_W-1:0] rows_val,
                          input logic [ippc_pkg::CFG_W-1:0] cols_val);
    drain();
    write_reg(ippc_pkg::REG_GRID_ROWS, rows_val);
    write_reg(ippc_pkg::REG_GRID_COLS, cols_val);
    frame_rows = span_of(rows_val, ippc_pkg::MAX_ROWS);
    frame_cols = span_of(cols_val, ippc_pkg::MAX_COLS);
    size_settings++;
  endtask

  task automatic clear_picture();
    foreach (pic[k]) pic[k] = '0;
  endtask

  // Draw a plus centered at (r, c), clipping arms at the grid edge.
  task automatic put_plus(input int r, input int c);
    pic[r][c] = 1'b1;
    if (r >= 1) pic[r-1][c] = 1'b1;
    if (r + 1 < frame_rows) pic[r+1][c] = 1'b1;
    if (c >= 1) pic[r][c-1] = 1'b1;
    if (c + 1 < frame_cols) pic[r][c+1] = 1'b1;
  endtask

  task automatic sprinkle(input int pct);
    for (int r = 0; r < frame_rows; r++)
      for (int c = 0; c < frame_cols; c++)
        pic[r][c] = ($urandom_range(99) < pct);
  endtask

  // Mostly scattered pluses on a clear background with a few flipped cells,
  // so that many centers get through the arm test and reach the isolation
  // checks; the rest is plain noise and the odd solid frame.
  task automatic random_picture();
    int mode;
    int r;
    int c;
    clear_picture();
    mode = $urandom_range(9);
    if (mode < 6) begin
      repeat ($urandom_range(1, frame_rows * frame_cols / 8 + 1))
        put_plus($urandom_range(frame_rows - 1), $urandom_range(frame_cols - 1));
      repeat ($urandom_range(2)) begin
        r = $urandom_range(frame_rows - 1);
        c = $urandom_range(frame_cols - 1);
        pic[r][c] = ~pic[r][c];
      end
    end else if (mode < 9) begin
      sprinkle($urandom_range(10, 90));
    end else begin
      sprinkle(100);
    end
  endtask

  // Mostly 3..8, some degenerate sizes (zero acts as one), a few up to 16.
  function automatic logic [ippc_pkg::CFG_W-1:0] pick_size();
    int roll;
    roll = $urandom_range(99);
    if (roll < 12) return ippc_pkg::CFG_W'($urandom_range(2));
    if (roll < 88) return ippc_pkg::CFG_W'($urandom_range(3, 8));
    return ippc_pkg::CFG_W'($urandom_range(9, 16));
  endfunction

  // Batches of one to four frames at one size; now and then abandon a
  // half-sent frame with a size write, which must restart the count.
  task automatic random_phase(input int tx_pct, input int rx_pct, input int goal);
    int sent;
    int cut;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    sent = 0;
    while (sent < goal) begin
      if ($urandom_range(9) == 0) begin
        cut = $urandom_range(frame_rows * frame_cols - 1);
        random_picture();
        send_frame(cut);
        sent += cut;
      end
      set_grid(pick_size(), pick_size());
      repeat ($urandom_range(1, 4)) begin
        random_picture();
        send_frame(frame_rows * frame_cols);
        sent += frame_rows * frame_cols;
      end
    end
  endtask

  initial begin
    int k;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    tx_idle_pct = 10;
    rx_idle_pct = 30;

    // Prime every column of the row store with one 1 x 1024 frame (row size
    // zero acts as one, 2047 acts as 1024) so that no later frame reads a
    // store entry that was never written.
    set_grid(11'd0, 11'd2047);
    clear_picture();
    sprinkle(50);
    send_frame(frame_rows * frame_cols);

    // Tall narrow grid: three columns, a stack of isolated pluses four rows
    // apart.
    set_grid(11'd40, 11'd3);
    clear_picture();
    for (k = 1; k + 2 <= frame_rows; k += 4) put_plus(k, 1);
    send_frame(frame_rows * frame_cols);

    // Smallest grid with a plus; far cells all lie beyond the edge.
    set_grid(11'd3, 11'd3);
    clear_picture();
    put_plus(1, 1);
    send_frame(9);
    clear_picture();
    sprinkle(100);
    send_frame(9);

    // Restart: abandon a frame after four cells, rewrite the size, resend.
    clear_picture();
    put_plus(1, 1);
    send_frame(4);
    set_grid(11'd3, 11'd3);
    send_frame(9);

    // Under three rows or columns the count is always zero.
    set_grid(11'd2, 11'd5);
    sprinkle(100);
    send_frame(frame_rows * frame_cols);
    set_grid(11'd5, 11'd2);
    sprinkle(100);
    send_frame(frame_rows * frame_cols);

    // 4 x 4: far cells inside the grid are checked, beyond the edge not.
    set_grid(11'd4, 11'd4);
    clear_picture();
    put_plus(1, 1);
    pic[3][1] = 1'b1;
    send_frame(16);
    clear_picture();
    put_plus(1, 1);
    pic[1][3] = 1'b1;
    send_frame(16);
    clear_picture();
    put_plus(1, 1);
    send_frame(16);
    clear_picture();
    put_plus(2, 2);
    send_frame(16);

    // 5 x 5: clean plus, then a diagonal and far cells up and right set.
    set_grid(11'd5, 11'd5);
    clear_picture();
    put_plus(2, 2);
    send_frame(25);
    pic[1][1] = 1'b1;
    send_frame(25);
    clear_picture();
    put_plus(2, 2);
    pic[0][2] = 1'b1;
    send_frame(25);
    clear_picture();
    put_plus(2, 2);
    pic[2][4] = 1'b1;
    send_frame(25);

    // Back-pressure: one-cell frames give a count per cell; hold the
    // receiver off for a long stretch while the sender keeps offering, so
    // the cell queue fills and in_ready drops.
    set_grid(11'd1, 11'd1);
    tx_idle_pct = 0;
    @(negedge clk);
    stall_left = PRESS_HOLD;
    @(posedge clk);
    for (k = 0; k < 40; k++) push_cell(1'($urandom_range(1)));

    // Random frames: a slow receiver, then a slow sender, then full rate.
    random_phase(15, 64, 40);
    random_phase(64, 15, 40);
    random_phase(0, 0, 40);

    drain();
    $display("Covered %0d cells in %0d checked frames over %0d grid settings,",
             cells_taken, frames_checked, size_settings);
    $display("with idling on both sides and one long output hold-off; peak count %0d.",
             peak_count);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/ippc_pkg.sv
rtl/core/ippc_front.sv
rtl/core/ippc_queue.sv
rtl/core/ippc_back.sv
rtl/core/isolated_plus_pattern_counter.sv
tb/ippc_frame_checker.sv
tb/tb_top.sv
